[rtl/dual_pid_windowed_integral_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual PID core
// Clocked assertion forms that can be removed as a group with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DUAL_PID_WINDOWED_INTEGRAL_CORE_ASSERT_SVH
`define DUAL_PID_WINDOWED_INTEGRAL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPWI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DPWI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DPWI_ASSERT(lbl, prop, msg)
`define DPWI_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/dpwi_pkg.sv]
// ----------------------------------------------------------------------------
// Dual PID package
// Register indexes and fixed field widths of the dual PID core.
// ----------------------------------------------------------------------------
package dpwi_pkg;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int DRIVE_W = 32;
    localparam int IDX_W   = 3;
    localparam int FRAC_SHIFT = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_STEER_P = 3'd0,
        REG_STEER_I = 3'd1,
        REG_STEER_D = 3'd2,
        REG_SPEED_P = 3'd3,
        REG_SPEED_I = 3'd4,
        REG_SPEED_D = 3'd5
    } reg_index_t;

    localparam int CH_STEER = 0;
    localparam int CH_SPEED = 1;
    localparam int NUM_CH   = 2;

endpackage

[rtl/dual_pid_windowed_integral_core.sv]
// ----------------------------------------------------------------------------
// Dual PID core with windowed integral
// Two independent PID channels, steering and speed, in Q8.8 in and Q24.8 out.
// ----------------------------------------------------------------------------
// Each input item on s_tdata carries one error sample per channel. The block
// keeps, per channel, the previous sample and a shift line of the last
// WINDOW_LEN samples with their running sum, and forms Kp*e + Ki*sum + Kd*diff
// with signed Q8.16 gains, floored to Q24.8 and saturated to 32 bits.
// Gains are written through the cfg channel, which is always ready; the user
// must see that they are written only while no item is in flight, as the
// block itself does not enforce it. The pipeline has three register stages:
// state update, products, and the final sum with saturation. One item can be
// accepted in every cycle unless the pipeline is full and the receiver stalls.
// When the receiver stalls, each stage holds only if the one after it is full,
// so up to three items are absorbed before s_tready falls.
// Reset clears the gains, the sample history, the sums and all valid bits;
// the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "dual_pid_windowed_integral_core_assert.svh"

module dual_pid_windowed_integral_core
    import dpwi_pkg::*;
#(
    parameter int WINDOW_LEN = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // steer_error [15:0], speed_error [31:16]
    input  logic [2*ERR_W-1:0]         s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // steer_drive [31:0], speed_drive [63:32]
    output logic [2*DRIVE_W-1:0]       m_tdata
);

    localparam int SUM_W  = ERR_W + $clog2(WINDOW_LEN);
    localparam int DIFF_W = ERR_W + 1;
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + SUM_W;
    localparam int PD_W   = GAIN_W + DIFF_W;
    localparam int ACC_RAW_W = GAIN_W + SUM_W + 2;
    localparam int ACC_W  = (ACC_RAW_W > DRIVE_W + FRAC_SHIFT) ? ACC_RAW_W
                                                               : DRIVE_W + FRAC_SHIFT + 1;
    localparam int Q_W    = ACC_W - FRAC_SHIFT;

    logic signed [GAIN_W-1:0] gain_p_reg [NUM_CH];
    logic signed [GAIN_W-1:0] gain_i_reg [NUM_CH];
    logic signed [GAIN_W-1:0] gain_d_reg [NUM_CH];

    logic signed [ERR_W-1:0]  hist_reg [NUM_CH][WINDOW_LEN];
    logic signed [ERR_W-1:0]  last_reg [NUM_CH];
    logic signed [SUM_W-1:0]  sum_reg  [NUM_CH];
    logic signed [ERR_W-1:0]  err_in   [NUM_CH];
    logic signed [SUM_W-1:0]  sum_next [NUM_CH];
    logic signed [DIFF_W-1:0] diff_next [NUM_CH];

    logic                     a_valid_reg;
    logic signed [ERR_W-1:0]  a_err_reg  [NUM_CH];
    logic signed [SUM_W-1:0]  a_sum_reg  [NUM_CH];
    logic signed [DIFF_W-1:0] a_diff_reg [NUM_CH];

    logic                     b_valid_reg;
    logic signed [PP_W-1:0]   b_prod_p_reg [NUM_CH];
    logic signed [PI_W-1:0]   b_prod_i_reg [NUM_CH];
    logic signed [PD_W-1:0]   b_prod_d_reg [NUM_CH];
    logic signed [PP_W-1:0]   prod_p_next  [NUM_CH];
    logic signed [PI_W-1:0]   prod_i_next  [NUM_CH];
    logic signed [PD_W-1:0]   prod_d_next  [NUM_CH];

    logic                     m_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg  [NUM_CH];
    logic [DRIVE_W-1:0]       drive_next [NUM_CH];
    logic signed [ACC_W-1:0]  acc        [NUM_CH];
    logic signed [Q_W-1:0]    quot       [NUM_CH];

    logic en_a, en_b, en_c, accept;

    assign en_c   = !m_valid_reg || m_tready;
    assign en_b   = !b_valid_reg || en_c;
    assign en_a   = !a_valid_reg || en_b;
    assign accept = s_tvalid && en_a;

    assign s_tready  = en_a;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {drive_reg[CH_SPEED], drive_reg[CH_STEER]};

    assign err_in[CH_STEER] = s_tdata[ERR_W-1:0];
    assign err_in[CH_SPEED] = s_tdata[2*ERR_W-1:ERR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                gain_p_reg[c] <= '0;
                gain_i_reg[c] <= '0;
                gain_d_reg[c] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEER_P: gain_p_reg[CH_STEER] <= cfg_data;
                REG_STEER_I: gain_i_reg[CH_STEER] <= cfg_data;
                REG_STEER_D: gain_d_reg[CH_STEER] <= cfg_data;
                REG_SPEED_P: gain_p_reg[CH_SPEED] <= cfg_data;
                REG_SPEED_I: gain_i_reg[CH_SPEED] <= cfg_data;
                REG_SPEED_D: gain_d_reg[CH_SPEED] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            sum_next[c] = sum_reg[c] + SUM_W'(err_in[c]) - SUM_W'(hist_reg[c][WINDOW_LEN-1]);
            diff_next[c] = DIFF_W'(err_in[c]) - DIFF_W'(last_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                last_reg[c] <= '0;
                sum_reg[c]  <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    hist_reg[c][i] <= '0;
                end
            end
        end else if (accept) begin
            for (int c = 0; c < NUM_CH; c++) begin
                last_reg[c]    <= err_in[c];
                sum_reg[c]     <= sum_next[c];
                hist_reg[c][0] <= err_in[c];
                for (int i = 1; i < WINDOW_LEN; i++) begin
                    hist_reg[c][i] <= hist_reg[c][i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int c = 0; c < NUM_CH; c++) begin
                a_err_reg[c]  <= err_in[c];
                a_sum_reg[c]  <= sum_next[c];
                a_diff_reg[c] <= diff_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod_p_next[c] = gain_p_reg[c] * a_err_reg[c];
            prod_i_next[c] = gain_i_reg[c] * a_sum_reg[c];
            prod_d_next[c] = gain_d_reg[c] * a_diff_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b && a_valid_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                b_prod_p_reg[c] <= prod_p_next[c];
                b_prod_i_reg[c] <= prod_i_next[c];
                b_prod_d_reg[c] <= prod_d_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc[c] = ACC_W'(b_prod_p_reg[c]) + ACC_W'(b_prod_i_reg[c])
                   + ACC_W'(b_prod_d_reg[c]);
            quot[c] = acc[c][ACC_W-1:FRAC_SHIFT];
            if (quot[c][Q_W-1:DRIVE_W-1] == '0 || quot[c][Q_W-1:DRIVE_W-1] == '1) begin
                drive_next[c] = quot[c][DRIVE_W-1:0];
            end else if (quot[c][Q_W-1]) begin
                drive_next[c] = {1'b1, {(DRIVE_W-1){1'b0}}};
            end else begin
                drive_next[c] = {1'b0, {(DRIVE_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_c) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c && b_valid_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                drive_reg[c] <= drive_next[c];
            end
        end
    end

    `DPWI_ASSERT(a_idle_out_ready, !m_tvalid |-> s_tready, "Input stalled with an empty output stage.")
    `DPWI_ASSERT(a_accept_fills, (s_tvalid && s_tready) |=> a_valid_reg, "Accepted item was not captured in the first stage.")
    `DPWI_ASSERT(a_stage_moves, (b_valid_reg && en_c) |=> m_tvalid, "Product stage did not reach the output register.")
    `DPWI_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "Output valid after reset.")

endmodule
